@@ rtl/core/cdsw_pkg.sv @@
// Package for the serial character display writer.
// Holds mode codes, frame constants, display size defaults and the frame builder.
// No dependencies.
package cdsw_pkg;

  // Item modes
  typedef enum logic [1:0] {
    MODE_CHAR   = 2'd0,
    MODE_CURSOR = 2'd1,
    MODE_CMD    = 2'd2,
    MODE_DATA   = 2'd3
  } mode_e;

  localparam int unsigned FrameBits    = 24;
  localparam int unsigned CountW       = 6;
  localparam int unsigned ColumnCountD = 20;
  localparam int unsigned RowCountD    = 4;

  // Set-address command base for each display line
  localparam logic [3:0][7:0] LineBase = {8'hE0, 8'hC0, 8'hA0, 8'h80};

  typedef logic [FrameBits-1:0] frame_t;

  // Frame pending for the serializer; frames[23:0] goes out first
  typedef struct packed {
    logic                   valid;
    logic                   two;
    logic [2*FrameBits-1:0] frames;
  } pend_t;

  // Build one frame, bit 0 is sent first
  function automatic frame_t build_frame(logic is_data, logic [7:0] payload);
    frame_t f;
    f        = '0;
    f[4:0]   = 5'b11111;
    f[6]     = is_data;
    f[11:8]  = payload[3:0];
    f[19:16] = payload[7:4];
    return f;
  endfunction

endpackage

@@ rtl/core/cdsw_if.sv @@
// Channel interfaces for the serial character display writer.
// Depends on nothing but plain logic types.
interface cdsw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] value;
  logic [5:0] col;
  logic [2:0] row;

  modport source (output valid, mode, value, col, row, input ready);
  modport sink   (input valid, mode, value, col, row, output ready);
endinterface

interface cdsw_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic frame_end;
  logic last;

  modport source (output valid, serial_bit, frame_end, last, input ready);
  modport sink   (input valid, serial_bit, frame_end, last, output ready);
endinterface

@@ rtl/core/char_display_serial_writer.sv @@
// Top level of the serial character display writer.
// Depends on cdsw_pkg, cdsw_if, cdsw_decode and cdsw_serializer.
//
// Usage:
//   in_i carries one item per transfer: mode, value, col, row.
//   out_o carries one data-line bit per transfer with frame_end on the
//   24th bit of each frame and last on the final bit of an item.
//   A character write yields 48 bits (address frame, then data frame),
//   a raw command or raw data yields 24 bits, set cursor yields none.
//   An accepted item is registered in the pending register, then loaded
//   into the shift register, from which its first bit is offered.
//   Throughput: the serializer sends one bit per cycle while the receiver
//   is ready; the next item's bits follow the previous item's last bit
//   with no gap when the next item is already pending. One decoded item
//   waits in the pending register while the serializer works; set cursor
//   items pass at one per cycle while the pending register is free or taken.
//   Reset: cursor goes to column 0, line 0; no bits pending.
//   When the receiver stalls, the current bit holds and the input side
//   stops accepting once the pending register is full.
module char_display_serial_writer #(
  parameter int unsigned COLUMN_COUNT = cdsw_pkg::ColumnCountD,
  parameter int unsigned ROW_COUNT    = cdsw_pkg::RowCountD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdsw_in_if.sink    in_i,
  cdsw_out_if.source out_o
);

  cdsw_pkg::pend_t pend;
  logic            take;

  // Cursor tracking and frame composition
  cdsw_decode #(
    .COLUMN_COUNT (COLUMN_COUNT),
    .ROW_COUNT    (ROW_COUNT)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .pend_o (pend)
  );

  // Bit serializer
  cdsw_serializer u_serializer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pend_i (pend),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule

@@ rtl/core/cdsw_decode.sv @@
// Input stage: cursor tracking and frame composition into a pending register.
// Depends on cdsw_pkg and cdsw_in_if.
module cdsw_decode #(
  parameter int unsigned COLUMN_COUNT = cdsw_pkg::ColumnCountD,
  parameter int unsigned ROW_COUNT    = cdsw_pkg::RowCountD
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cdsw_in_if.sink        in_i,
  input  logic           take_i,
  output cdsw_pkg::pend_t pend_o
);

  logic [4:0]      col_q, col_d;
  logic [1:0]      line_q, line_d;
  cdsw_pkg::pend_t pend_q, pend_d;
  logic            accept;
  logic [5:0]      col_inc;
  logic [2:0]      line_inc;
  logic [7:0]      addr;

  assign in_i.ready = !pend_q.valid || take_i;
  assign accept     = in_i.valid && in_i.ready;
  assign pend_o     = pend_q;

  // Compose address and cursor advance
  always_comb begin
    col_inc  = {1'b0, col_q} + 6'd1;
    line_inc = {1'b0, line_q} + 3'd1;
    addr     = cdsw_pkg::LineBase[line_q] + {3'b000, col_q};
  end

  // Next cursor and pending frame
  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    pend_d = pend_q;
    if (take_i) begin
      pend_d.valid = 1'b0;
    end
    if (accept) begin
      case (cdsw_pkg::mode_e'(in_i.mode))
        cdsw_pkg::MODE_CHAR: begin
          pend_d.valid  = 1'b1;
          pend_d.two    = 1'b1;
          pend_d.frames = {cdsw_pkg::build_frame(1'b1, in_i.value),
                           cdsw_pkg::build_frame(1'b0, addr)};
          if (col_inc >= 6'(COLUMN_COUNT)) begin
            col_d  = '0;
            line_d = (line_inc >= 3'(ROW_COUNT)) ? 2'd0 : line_inc[1:0];
          end else begin
            col_d  = col_inc[4:0];
          end
        end
        cdsw_pkg::MODE_CURSOR: begin
          if (in_i.col < 6'(COLUMN_COUNT) && in_i.row < 3'(ROW_COUNT)) begin
            col_d  = in_i.col[4:0];
            line_d = in_i.row[1:0];
          end else begin
            col_d  = '0;
            line_d = '0;
          end
        end
        cdsw_pkg::MODE_CMD: begin
          pend_d.valid  = 1'b1;
          pend_d.two    = 1'b0;
          pend_d.frames = {cdsw_pkg::FrameBits'(0),
                           cdsw_pkg::build_frame(1'b0, in_i.value)};
        end
        default: begin
          pend_d.valid  = 1'b1;
          pend_d.two    = 1'b0;
          pend_d.frames = {cdsw_pkg::FrameBits'(0),
                           cdsw_pkg::build_frame(1'b1, in_i.value)};
        end
      endcase
    end
  end

  // Hold cursor and pending frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
      pend_q <= '0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
      pend_q <= pend_d;
    end
  end

endmodule

@@ rtl/core/cdsw_serializer.sv @@
// Output stage: shifts pending frames onto the data line, one bit per transfer.
// Depends on cdsw_pkg and cdsw_out_if.
module cdsw_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cdsw_pkg::pend_t pend_i,
  output logic            take_o,
  cdsw_out_if.source      out_o
);

  localparam logic [cdsw_pkg::CountW-1:0] OneFrame =
    cdsw_pkg::CountW'(cdsw_pkg::FrameBits);
  localparam logic [cdsw_pkg::CountW-1:0] TwoFrames =
    cdsw_pkg::CountW'(2 * cdsw_pkg::FrameBits);

  logic [2*cdsw_pkg::FrameBits-1:0] shift_q, shift_d;
  logic [cdsw_pkg::CountW-1:0]      cnt_q, cnt_d;
  logic                             xfer;

  assign xfer   = out_o.valid && out_o.ready;
  assign take_o = pend_i.valid && (cnt_q == '0 || (cnt_q == 6'd1 && out_o.ready));

  assign out_o.valid      = cnt_q != '0;
  assign out_o.serial_bit = shift_q[0];
  assign out_o.last       = cnt_q == 6'd1;
  assign out_o.frame_end  = cnt_q == 6'd1 || cnt_q == OneFrame + 6'd1;

  // Load a new item or advance one bit
  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    if (take_o) begin
      shift_d = pend_i.frames;
      cnt_d   = pend_i.two ? TwoFrames : OneFrame;
    end else if (xfer) begin
      shift_d = shift_q >> 1;
      cnt_d   = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= TwoFrames)
    else $error("bit count out of range");
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> out_o.frame_end)
    else $error("last bit not at frame end");
  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> cnt_q == OneFrame || cnt_q == TwoFrames)
    else $error("bad count after load");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(cnt_q))
    else $error("count moved while stalled");
`endif

endmodule

@@ verif/tb_top.sv @@
// Testbench for the serial character display writer: directed table, then random items.
// Predicts every data-line bit from a local cursor model and checks each output transfer.
// Depends on cdsw_pkg, cdsw_if and char_display_serial_writer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLS       = 20;
  localparam int unsigned ROWS       = 4;
  localparam int unsigned FRAME_LEN  = 24;
  localparam int unsigned NUM_DIR    = 25;
  localparam int unsigned NUM_PHASES = 4;
  localparam int unsigned PHASE_ITEMS = 36;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // One data-line bit as seen on the output channel
  typedef struct packed {
    logic sbit;
    logic frame_end;
    logic last;
  } line_bit_t;

  // One row of the directed table; addr is typed in for character writes where known
  typedef struct {
    cdsw_pkg::mode_e mode;
    logic [7:0]      value;
    logic [5:0]      col;
    logic [2:0]      row;
    bit              has_addr;
    logic [7:0]      addr;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  cdsw_in_if  in_bus ();
  cdsw_out_if out_bus ();

  char_display_serial_writer #(
    .COLUMN_COUNT(COLS),
    .ROW_COUNT   (ROWS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  line_bit_t   expected_line_bits[$];
  logic [4:0]  cur_col;
  logic [1:0]  cur_line;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  stim_row_t dir_rows [NUM_DIR] = '{
    '{cdsw_pkg::MODE_CHAR,   8'h41, 6'd0,  3'd0, 1'b1, 8'h80}, // first character lands at home
    '{cdsw_pkg::MODE_CMD,    8'h00, 6'd0,  3'd0, 1'b0, 8'h00},
    '{cdsw_pkg::MODE_CMD,    8'hFF, 6'd0,  3'd0, 1'b0, 8'h00},
    '{cdsw_pkg::MODE_DATA,   8'h00, 6'd0,  3'd0, 1'b0, 8'h00},
    '{cdsw_pkg::MODE_DATA,   8'hFF, 6'd0,  3'd0, 1'b0, 8'h00},
    '{cdsw_pkg::MODE_DATA,   8'hA5, 6'd0,  3'd0, 1'b0, 8'h00},
    '{cdsw_pkg::MODE_CURSOR, 8'h00, 6'd19, 3'd3, 1'b0, 8'h00}, // last cell of the screen
    '{cdsw_pkg::MODE_CHAR,   8'hFF, 6'd0,  3'd0, 1'b1, 8'hF3}, // wraps back to home
    '{cdsw_pkg::MODE_CHAR,   8'h00, 6'd0,  3'd0, 1'b1, 8'h80},
    '{cdsw_pkg::MODE_CURSOR, 8'h00, 6'd20, 3'd0, 1'b0, 8'h00}, // column one past the end
    '{cdsw_pkg::MODE_CHAR,   8'h5A, 6'd0,  3'd0, 1'b1, 8'h80},
    '{cdsw_pkg::MODE_CURSOR, 8'h00, 6'd5,  3'd2, 1'b0, 8'h00},
    '{cdsw_pkg::MODE_CHAR,   8'h33, 6'd0,  3'd0, 1'b1, 8'hC5},
    '{cdsw_pkg::MODE_CURSOR, 8'h00, 6'd0,  3'd4, 1'b0, 8'h00}, // row one past the end
    '{cdsw_pkg::MODE_CHAR,   8'h7E, 6'd0,  3'd0, 1'b1, 8'h80},
    '{cdsw_pkg::MODE_CURSOR, 8'h00, 6'd63, 3'd7, 1'b0, 8'h00}, // both fields at their maximum
    '{cdsw_pkg::MODE_CHAR,   8'h80, 6'd0,  3'd0, 1'b1, 8'h80},
    '{cdsw_pkg::MODE_CURSOR, 8'h00, 6'd19, 3'd0, 1'b0, 8'h00},
    '{cdsw_pkg::MODE_CHAR,   8'h01, 6'd0,  3'd0, 1'b1, 8'h93}, // end of line 0
    '{cdsw_pkg::MODE_CHAR,   8'hFE, 6'd0,  3'd0, 1'b1, 8'hA0}, // moved on to line 1
    '{cdsw_pkg::MODE_CURSOR, 8'hFF, 6'd19, 3'd1, 1'b0, 8'h00}, // value has no effect here
    '{cdsw_pkg::MODE_CHAR,   8'h55, 6'd0,  3'd0, 1'b1, 8'hB3},
    '{cdsw_pkg::MODE_CHAR,   8'hAA, 6'd0,  3'd0, 1'b1, 8'hC0},
    '{cdsw_pkg::MODE_CMD,    8'h01, 6'd63, 3'd7, 1'b0, 8'h00}, // col and row have no effect
    '{cdsw_pkg::MODE_CURSOR, 8'h00, 6'd0,  3'd0, 1'b0, 8'h00}
  };

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Queue the 24 bits of one frame; mark the final bit of the item if asked
  task automatic push_frame(input logic is_data, input logic [7:0] payload,
                            input bit ends_item);
    line_bit_t lb;
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i < 5)
        lb.sbit = 1'b1;
      else if (i == 6)
        lb.sbit = is_data;
      else if (i >= 8 && i < 12)
        lb.sbit = payload[i-8];
      else if (i >= 16 && i < 20)
        lb.sbit = payload[i-12];
      else
        lb.sbit = 1'b0;
      lb.frame_end = (i == FRAME_LEN - 1);
      lb.last      = ends_item && (i == FRAME_LEN - 1);
      expected_line_bits.push_back(lb);
    end
  endtask

  // Work out the bits one accepted item causes and update the cursor
  task automatic predict_display_bits(input cdsw_pkg::mode_e m, input logic [7:0] v,
                                      input logic [5:0] c, input logic [2:0] r,
                                      input bit has_addr, input logic [7:0] addr);
    logic [7:0] set_addr;
    logic [4:0] next_col;
    case (m)
      cdsw_pkg::MODE_CHAR: begin
        set_addr = has_addr ? addr : cdsw_pkg::LineBase[cur_line] + {3'b000, cur_col};
        push_frame(1'b0, set_addr, 1'b0);
        push_frame(1'b1, v, 1'b1);
        // Advance the column, then the line, wrapping both
        next_col = cur_col + 5'd1;
        if (next_col == 5'd0 || next_col >= COLS) begin
          cur_col  = '0;
          cur_line = cur_line + 2'd1;
        end else begin
          cur_col = next_col;
        end
        if (cur_line >= ROWS) cur_line = '0;
      end
      cdsw_pkg::MODE_CURSOR: begin
        if (c < COLS && r < ROWS) begin
          cur_col  = c[4:0];
          cur_line = r[1:0];
        end else begin
          cur_col  = '0;
          cur_line = '0;
        end
      end
      cdsw_pkg::MODE_CMD: push_frame(1'b0, v, 1'b1);
      default:            push_frame(1'b1, v, 1'b1);
    endcase
  endtask

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input cdsw_pkg::mode_e m, input logic [7:0] v,
                           input logic [5:0] c, input logic [2:0] r,
                           input bit has_addr, input logic [7:0] addr);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      in_bus.mode  = 2'($urandom_range(3));
      in_bus.value = 8'($urandom);
      in_bus.col   = 6'($urandom);
      in_bus.row   = 3'($urandom);
      @(negedge clk_i);
    end
    in_bus.valid = 1'b1;
    in_bus.mode  = m;
    in_bus.value = v;
    in_bus.col   = c;
    in_bus.row   = r;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_display_bits(m, v, c, r, has_addr, addr);
  endtask

  // Drop valid and hold until every expected bit has been seen
  task automatic wait_line_idle();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (expected_line_bits.size() != 0) @(posedge clk_i);
  endtask

  // Build one random item: characters most often, cursor moves mostly in range
  task automatic send_random_item();
    int unsigned     pick;
    cdsw_pkg::mode_e m;
    logic [5:0]      c;
    logic [2:0]      r;
    pick = $urandom_range(99);
    if (pick < 40)      m = cdsw_pkg::MODE_CHAR;
    else if (pick < 62) m = cdsw_pkg::MODE_CURSOR;
    else if (pick < 81) m = cdsw_pkg::MODE_CMD;
    else                m = cdsw_pkg::MODE_DATA;
    if (m == cdsw_pkg::MODE_CURSOR && $urandom_range(99) < 75) begin
      c = 6'($urandom_range(COLS - 1));
      r = 3'($urandom_range(ROWS - 1));
    end else begin
      c = 6'($urandom);
      r = 3'($urandom);
    end
    send_item(m, 8'($urandom), c, r, 1'b0, 8'h00);
  endtask

  // Receiver: stall at random on the falling edge
  always @(negedge clk_i) begin
    out_bus.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each output transfer with the oldest expected bit
  always @(posedge clk_i) begin
    line_bit_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_line_bits.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected bit: expected none, actual sbit=%b frame_end=%b last=%b",
                 $time, out_bus.serial_bit, out_bus.frame_end, out_bus.last);
      end else begin
        want = expected_line_bits.pop_front();
        if (out_bus.serial_bit !== want.sbit) begin
          mismatch_count++;
          $display("%0t: serial_bit mismatch: expected %b, actual %b",
                   $time, want.sbit, out_bus.serial_bit);
        end
        if (out_bus.frame_end !== want.frame_end) begin
          mismatch_count++;
          $display("%0t: frame_end mismatch: expected %b, actual %b",
                   $time, want.frame_end, out_bus.frame_end);
        end
        if (out_bus.last !== want.last) begin
          mismatch_count++;
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, want.last, out_bus.last);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Main sequence
  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_col        = '0;
    cur_line       = '0;
    in_bus.valid   = 1'b0;
    in_bus.mode    = cdsw_pkg::MODE_CHAR;
    in_bus.value   = '0;
    in_bus.col     = '0;
    in_bus.row     = '0;
    rst_ni         = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table with light idling on both sides
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    foreach (dir_rows[i])
      send_item(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].col, dir_rows[i].row,
                dir_rows[i].has_addr, dir_rows[i].addr);

    // Random phases; drain the line before each so the sender pauses fully
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_line_idle();
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) send_random_item();
    end

    // Drain, then watch for stray bits
    wait_line_idle();
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_line_bits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/cdsw_pkg.sv
rtl/core/cdsw_if.sv
rtl/core/cdsw_decode.sv
rtl/core/cdsw_serializer.sv
rtl/core/char_display_serial_writer.sv
verif/tb_top.sv
